/* sv/rgb_image_psnr_top_macros.svh */
// ---------------------------------------------------------------------------
// rgb_image_psnr_top_macros.svh
// Assertion macros used by the PSNR block top level.
// ---------------------------------------------------------------------------
`ifndef RGB_IMAGE_PSNR_TOP_MACROS_SVH
`define RGB_IMAGE_PSNR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define RIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rip_pkg.sv */
// ---------------------------------------------------------------------------
// rip_pkg
// Shared types and constants of the RGB image PSNR block.
// ---------------------------------------------------------------------------
package rip_pkg;

  localparam int SSE_W   = 42;
  localparam int COUNT_W = 25;
  localparam int DIM_W   = 13;
  localparam int LOGX_W  = 43;  // count * 195075 fits in 43 bits

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // 255 * 255 * 3
  localparam logic [17:0] PEAK_SQ_CH = 18'd195075;

  // 2560 * log10(2) with 24 fraction bits, split for two partial products
  localparam logic [33:0] DB_PER_OCT = 34'd12929139865;
  localparam logic [16:0] DB_LO      = DB_PER_OCT[16:0];
  localparam logic [16:0] DB_HI      = DB_PER_OCT[33:17];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_NORM,
    ST_SQUARE,
    ST_CMP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DONE
  } log_state_t;

  // End-of-image request to the log unit
  typedef struct packed {
    logic               valid;
    logic [SSE_W-1:0]   sse;
    logic [COUNT_W-1:0] count;
  } start_t;

  // Finished result from the log unit
  typedef struct packed {
    logic             valid;
    logic [15:0]      psnr;
    logic             identical;
    logic [SSE_W-1:0] sse;
  } result_t;

endpackage

/* sv/rgb_image_psnr_top.sv */
// ---------------------------------------------------------------------------
// rgb_image_psnr_top
// RGB image PSNR: three color lanes square channel differences, a merge
// stage accumulates the exact error sum, and a log unit forms Q8.8 dB.
// ---------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid/in_ready + six color bytes  | pixel pair requests in
//  out     | out_valid/out_ready + psnr, flags    | one result per image
//  cfg     | cfg_valid/cfg_ready, index, data     | width/height writes
//
// One pixel per cycle within an image. After the last pixel the input
// stalls while the log unit runs its two bit-serial normalizations and
// 2 x 32 squarings on the 32x32 multiplier.
// The output register lets the next image start while a result waits.
// Reset is synchronous; width and height return to 1.
module rgb_image_psnr_top #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  test_red,
  input  logic [7:0]  test_green,
  input  logic [7:0]  test_blue,
  input  logic [7:0]  reference_red,
  input  logic [7:0]  reference_green,
  input  logic [7:0]  reference_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] psnr_q8_8,
  output logic        identical,
  output logic [41:0] squared_error_sum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  `include "rgb_image_psnr_top_macros.svh"

  logic [rip_pkg::DIM_W-1:0]   width;
  logic [rip_pkg::DIM_W-1:0]   height;
  logic [rip_pkg::DIM_W-1:0]   dim_clamped;
  logic [rip_pkg::COUNT_W-1:0] count;
  logic [rip_pkg::COUNT_W-1:0] count_inc;
  logic [rip_pkg::COUNT_W-1:0] final_count;
  logic [25:0]                 target;
  logic                        last;
  logic                        accept;
  logic                        busy;
  logic                        s1_valid;
  logic                        s1_last;
  logic [15:0]                 sq_r, sq_g, sq_b;
  logic [rip_pkg::SSE_W-1:0]   acc;
  logic [rip_pkg::SSE_W-1:0]   acc_sum;
  logic                        res_ready;
  rip_pkg::start_t             start;
  rip_pkg::result_t            res;

  // Configuration
  assign cfg_ready   = 1'b1;
  assign dim_clamped = (cfg_data == '0) ? 13'd1 :
                       (cfg_data > 13'(MAX_DIMENSION)) ? 13'(MAX_DIMENSION) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= 13'd1;
      height <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rip_pkg::REG_WIDTH:  width  <= dim_clamped;
        rip_pkg::REG_HEIGHT: height <= dim_clamped;
        default: ;
      endcase
    end
  end

  // Pixel count and end-of-image detect
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign count_inc = count + 25'd1;
  assign target    = width * height;
  assign last      = count_inc >= target[rip_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy     <= 1'b0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept && last;
      if (accept) begin
        count <= last ? '0 : count_inc;
        if (last) busy <= 1'b1;
      end else if (res.valid && res_ready) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) final_count <= count_inc;
  end

  // Color lanes
  rip_lane u_lane_r (.clk(clk), .en(accept), .a(test_red),   .b(reference_red),   .sq(sq_r));
  rip_lane u_lane_g (.clk(clk), .en(accept), .a(test_green), .b(reference_green), .sq(sq_g));
  rip_lane u_lane_b (.clk(clk), .en(accept), .a(test_blue),  .b(reference_blue),  .sq(sq_b));

  // Merge stage: accumulate the exact error sum
  assign acc_sum = acc + {24'd0, {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b}};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_valid) begin
      acc <= s1_last ? '0 : acc_sum;
    end
  end

  assign start.valid = s1_valid && s1_last;
  assign start.sse   = acc_sum;
  assign start.count = final_count;

  rip_log u_log (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      psnr_q8_8         <= res.psnr;
      identical         <= res.identical;
      squared_error_sum <= res.sse;
    end
  end

  `RIP_ASSERT_IMP(a_ident_sat, out_valid && identical, psnr_q8_8 == 16'hFFFF, "identical without saturated psnr")
  `RIP_ASSERT_IMP(a_ident_sse, out_valid && identical, squared_error_sum == '0, "identical with nonzero sum")
  `RIP_ASSERT_NXT(a_last_stall, accept && last, !in_ready, "input not stalled after last pixel")

endmodule

/* sv/rip_lane.sv */
// ---------------------------------------------------------------------------
// rip_lane
// One color lane: registered square of the absolute channel difference.
// ---------------------------------------------------------------------------
module rip_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  a,
  input  logic [7:0]  b,
  output logic [15:0] sq
);

  logic [7:0] diff;

  assign diff = (a >= b) ? (a - b) : (b - a);

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= diff * diff;
    end
  end

endmodule

/* sv/rip_log.sv */
// ---------------------------------------------------------------------------
// rip_log
// Per-image PSNR unit: two log2 evaluations by normalize and repeated
// squaring on one shared 32x32 multiplier, then dB scaling.
// ---------------------------------------------------------------------------
module rip_log (
  input  logic             clk,
  input  logic             rst,
  input  rip_pkg::start_t  start,
  input  logic             res_ready,
  output rip_pkg::result_t res
);

  rip_pkg::log_state_t state, state_next;

  logic [rip_pkg::LOGX_W-1:0]  x;
  logic [5:0]                  e;
  logic [31:0]                 m;
  logic [31:0]                 frac;
  logic [4:0]                  iter;
  logic                        phase;
  logic [37:0]                 ln;
  logic [37:0]                 ld;
  logic [rip_pkg::SSE_W-1:0]   sse_hold;
  logic [rip_pkg::COUNT_W-1:0] count_hold;
  logic [30:0]                 l24;
  logic [47:0]                 p_lo;
  logic [47:0]                 p_hi;
  logic [15:0]                 psnr;
  logic                        ident;

  logic [63:0] sq;
  logic [32:0] t;
  logic [31:0] frac_next;
  logic [38:0] l_rnd;
  logic [65:0] total;
  logic [17:0] r;

  assign sq        = m * m;
  assign t         = sq[63:31];
  assign frac_next = {frac[30:0], t[32]};
  assign l_rnd     = {1'b0, ln - ld} + 39'd128;
  assign total     = {18'd0, p_lo} + {1'b0, p_hi, 17'd0} + (66'd1 << 47);
  assign r         = total[65:48];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rip_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result handshake
  always_comb begin
    state_next    = state;
    res.valid     = 1'b0;
    res.psnr      = psnr;
    res.identical = ident;
    res.sse       = sse_hold;
    unique case (state)
      rip_pkg::ST_IDLE: begin
        if (start.valid) begin
          state_next = (start.sse == '0) ? rip_pkg::ST_DONE : rip_pkg::ST_PROD;
        end
      end
      rip_pkg::ST_PROD:   state_next = rip_pkg::ST_NORM;
      rip_pkg::ST_NORM: begin
        if (x[rip_pkg::LOGX_W-1]) state_next = rip_pkg::ST_SQUARE;
      end
      rip_pkg::ST_SQUARE: begin
        if (iter == 5'd31) begin
          state_next = phase ? rip_pkg::ST_CMP : rip_pkg::ST_NORM;
        end
      end
      rip_pkg::ST_CMP: begin
        state_next = (ld >= ln) ? rip_pkg::ST_DONE : rip_pkg::ST_MUL_LO;
      end
      rip_pkg::ST_MUL_LO: state_next = rip_pkg::ST_MUL_HI;
      rip_pkg::ST_MUL_HI: state_next = rip_pkg::ST_DONE;
      rip_pkg::ST_DONE: begin
        // psnr is final once the scaled value has been written
        res.valid = ident || (ld >= ln);
        if (res.valid && res_ready) state_next = rip_pkg::ST_IDLE;
      end
      default: state_next = rip_pkg::ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rip_pkg::ST_IDLE: begin
        sse_hold   <= start.sse;
        count_hold <= start.count;
        psnr       <= 16'hFFFF;
        ident      <= (start.sse == '0);
      end
      rip_pkg::ST_PROD: begin
        x     <= count_hold * rip_pkg::PEAK_SQ_CH;
        e     <= 6'(rip_pkg::LOGX_W - 1);
        phase <= 1'b0;
      end
      rip_pkg::ST_NORM: begin
        // one bit of normalization per cycle
        if (x[rip_pkg::LOGX_W-1]) begin
          m    <= x[rip_pkg::LOGX_W-1 -: 32];
          iter <= '0;
          frac <= '0;
        end else begin
          x <= {x[rip_pkg::LOGX_W-2:0], 1'b0};
          e <= e - 6'd1;
        end
      end
      rip_pkg::ST_SQUARE: begin
        m    <= t[32] ? t[32:1] : t[31:0];
        frac <= frac_next;
        iter <= iter + 5'd1;
        if (iter == 5'd31) begin
          if (phase) begin
            ld <= {e, frac_next};
          end else begin
            ln    <= {e, frac_next};
            x     <= {1'b0, sse_hold};
            e     <= 6'(rip_pkg::LOGX_W - 1);
            phase <= 1'b1;
          end
        end
      end
      rip_pkg::ST_CMP: begin
        l24 <= l_rnd[38:8];
        if (ld >= ln) psnr <= '0;
      end
      rip_pkg::ST_MUL_LO: p_lo <= l24 * rip_pkg::DB_LO;
      rip_pkg::ST_MUL_HI: p_hi <= l24 * rip_pkg::DB_HI;
      rip_pkg::ST_DONE: begin
        if (!ident && (ld < ln)) begin
          psnr <= (r > 18'd65535) ? 16'hFFFF : r[15:0];
          ident <= 1'b0;
          ld    <= ln;  // marks psnr as final and holds it while waiting
        end
      end
      default: ;
    endcase
  end

endmodule

/* bench/psnr_checker.sv */
// ---------------------------------------------------------------------------
// psnr_checker
// Watches the pixel, result and register channels of the RGB PSNR block.
// Keeps its own copy of the error sum, pixel count and image size, predicts
// each end-of-image result and compares it field by field on arrival.
// ---------------------------------------------------------------------------
module psnr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  test_red,
  input  logic [7:0]  test_green,
  input  logic [7:0]  test_blue,
  input  logic [7:0]  reference_red,
  input  logic [7:0]  reference_green,
  input  logic [7:0]  reference_blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] psnr_q8_8,
  input  logic        identical,
  input  logic [41:0] squared_error_sum,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output int          pending,
  output int          errors,
  output int          images_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]               psnr;
    logic                      same;
    logic [rip_pkg::SSE_W-1:0] sse;
  } image_score_t;

  image_score_t                score_queue[$];
  logic [rip_pkg::SSE_W-1:0]   sse_acc;
  logic [rip_pkg::COUNT_W-1:0] pix_count;
  logic [rip_pkg::DIM_W-1:0]   img_w, img_h;

  initial begin
    pending = 0;
    errors = 0;
    images_seen = 0;
  end

  function automatic logic [rip_pkg::DIM_W-1:0] clip_dim(logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  function automatic logic [17:0] chan_sq(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // log2 with 32 fraction bits: normalize, then 32 squaring rounds
  function automatic logic [63:0] log2_fixed(logic [63:0] x);
    logic [63:0] t, m, frac;
    int unsigned e;
    e = 0;
    t = x;
    frac = '0;
    if (x == 64'd0) return 64'd0;
    while (t > 64'd1) begin
      t >>= 1;
      e++;
    end
    if (e <= 31) m = x << (31 - e);
    else m = x >> (e - 31);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if (m >= 64'h1_0000_0000) begin
        m >>= 1;
        frac |= 64'd1;
      end
    end
    return (64'(e) << 32) | frac;
  endfunction

  function automatic logic [15:0] db_from_error(logic [63:0] sse, logic [63:0] n);
    logic [63:0] ln, ld, l24, r;
    ln = log2_fixed(n * 64'(rip_pkg::PEAK_SQ_CH));
    ld = log2_fixed(sse);
    if (ld >= ln) return 16'd0;
    l24 = (ln - ld + 64'd128) >> 8;
    r = (l24 * 64'(rip_pkg::DB_PER_OCT) + (64'd1 << 47)) >> 48;
    if (r > 64'd65535) r = 64'd65535;
    return r[15:0];
  endfunction

  always @(posedge clk) begin
    image_score_t want;
    logic [rip_pkg::COUNT_W-1:0] target;
    int bad;
    if (rst) begin
      sse_acc = '0;
      pix_count = '0;
      img_w = 13'd1;
      img_h = 13'd1;
      score_queue.delete();
    end else begin
      bad = 0;
      // results first: a result never belongs to a request of the same edge
      if (out_valid && out_ready) begin
        if (score_queue.size() == 0) begin
          $error("result with nothing expected: psnr %0d sse %0d",
                 psnr_q8_8, squared_error_sum);
          bad++;
        end else begin
          want = score_queue.pop_front();
          if (psnr_q8_8 !== want.psnr) begin
            $error("psnr_q8_8 expected %0d actual %0d", want.psnr, psnr_q8_8);
            bad++;
          end
          if (identical !== want.same) begin
            $error("identical expected %0d actual %0d", want.same, identical);
            bad++;
          end
          if (squared_error_sum !== want.sse) begin
            $error("squared_error_sum expected %0d actual %0d",
                   want.sse, squared_error_sum);
            bad++;
          end
        end
        images_seen <= images_seen + 1;
      end
      // pixel request: accumulate, close the image when the count is reached
      if (in_valid && in_ready) begin
        sse_acc = sse_acc + chan_sq(test_red, reference_red)
                + chan_sq(test_green, reference_green)
                + chan_sq(test_blue, reference_blue);
        pix_count = pix_count + 25'd1;
        target = img_w * img_h;
        if (pix_count >= target) begin
          want.sse = sse_acc;
          want.same = (sse_acc == '0);
          want.psnr = want.same ? 16'hFFFF : db_from_error(64'(sse_acc), 64'(pix_count));
          score_queue.push_back(want);
          sse_acc = '0;
          pix_count = '0;
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rip_pkg::REG_WIDTH) img_w = clip_dim(cfg_data);
        else if (cfg_index == rip_pkg::REG_HEIGHT) img_h = clip_dim(cfg_data);
      end
      errors <= errors + bad;
    end
    pending <= score_queue.size();
  end

endmodule

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Stimulus for the RGB PSNR block: directed pixel pairs, zero register values,
// a size change inside an image, then random images of mostly small sizes
// with random gaps on both sides. Checking is done by psnr_checker.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;
  localparam int PIXEL_GOAL   = 1700;

  // pixel content styles
  typedef enum int {PX_RANDOM, PX_SAME, PX_NEAR, PX_EXTREME} pix_style_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  test_red = 0, test_green = 0, test_blue = 0;
  logic [7:0]  reference_red = 0, reference_green = 0, reference_blue = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] psnr_q8_8;
  logic        identical;
  logic [41:0] squared_error_sum;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = rip_pkg::REG_WIDTH;
  logic [12:0] cfg_data = 0;

  int pending, errors, images_seen;
  int pixels_sent = 0;
  int stall_cycles = 0;
  bit hold_req = 0;
  bit quiet_tx = 0;

  rgb_image_psnr_top dut (.*);

  psnr_checker u_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: no request moved on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d results pending", pending);
      $display("testbench: errors");
      $finish;
    end
  end

  // result side: random back-pressure, calm stretches, one long hold
  initial begin
    int gap;
    bit quiet_rx;
    quiet_rx = 0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
      gap = quiet_rx ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(input logic [7:0] tr, tg, tb, rr, rg, rb);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    test_red <= tr;
    test_green <= tg;
    test_blue <= tb;
    reference_red <= rr;
    reference_green <= rg;
    reference_blue <= rb;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  function automatic logic [7:0] near_byte(logic [7:0] v);
    return v + 8'($urandom_range(0, 4)) - 8'd2;
  endfunction

  task automatic send_styled(input pix_style_t style);
    logic [7:0] r, g, b;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case (style)
      PX_SAME: send_pixel(r, g, b, r, g, b);
      PX_NEAR: send_pixel(r, g, b, near_byte(r), near_byte(g), near_byte(b));
      PX_EXTREME: begin
        r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_pixel(r, g, b, ~r, ~g, ~b);
      end
      default: send_pixel(r, g, b, 8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  // wait for all results, then let the log unit settle
  task automatic drain_results();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_size(input logic [12:0] w, input logic [12:0] h);
    drain_results();
    write_reg(rip_pkg::REG_WIDTH, w);
    write_reg(rip_pkg::REG_HEIGHT, h);
  endtask

  // stimulus
  initial begin
    int phase, n_img, pix_per, style;
    logic [12:0] w, h, nw, nh;
    bit large_done;
    large_done = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, 1x1 images after reset
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00);
    send_pixel(8'hAA, 8'h55, 8'h0F, 8'h55, 8'hAA, 8'hF0);

    // zero width clamps to one, 1x2 images
    set_size(13'd0, 13'd2);
    repeat (4) send_styled(PX_EXTREME);

    // size shrinks inside an image: 4 of 6 pixels, then target 2
    set_size(13'd3, 13'd2);
    repeat (4) send_styled(PX_RANDOM);
    set_size(13'd1, 13'd2);
    send_styled(PX_NEAR);

    // random phases
    phase = 0;
    while (pixels_sent < PIXEL_GOAL) begin
      phase++;
      if (!large_done && phase == 6) begin
        // one wide image with zero height clamped to one row
        w = 13'd1024;
        h = 13'd0;
        n_img = 1;
        large_done = 1;
      end else begin
        w = 13'($urandom_range(0, 5));
        h = 13'($urandom_range(0, 5));
        n_img = $urandom_range(3, 12);
      end
      set_size(w, h);
      nw = (w == 13'd0) ? 13'd1 : (w > 13'd4096 ? 13'd4096 : w);
      nh = (h == 13'd0) ? 13'd1 : (h > 13'd4096 ? 13'd4096 : h);
      pix_per = nw * nh;
      quiet_tx = ($urandom_range(0, 3) == 0);
      if (phase == 4) begin
        // fill the block while results are held back
        quiet_tx = 1;
        hold_req = 1;
      end
      for (int k = 0; k < n_img; k++) begin
        style = $urandom_range(0, 9);
        for (int p = 0; p < pix_per; p++) begin
          if (style == 0) send_styled(PX_SAME);
          else if (style == 1) send_styled(PX_EXTREME);
          else if (style <= 3) send_styled(PX_NEAR);
          else send_styled(PX_RANDOM);
        end
      end
      quiet_tx = 0;
    end

    drain_results();
    $display("covered %0d pixel pairs in %0d images over %0d size phases",
             pixels_sent, images_seen, phase + 3);
    $display("sizes from 1x1 to 1024x1, zero register values, mid-image resize");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* rgb_image_psnr_top.f */
+incdir+sv
sv/rip_pkg.sv
sv/rip_lane.sv
sv/rip_log.sv
sv/rgb_image_psnr_top.sv
bench/psnr_checker.sv
bench/testbench.sv
